// ===== src/scbp_pkg.sv =====
// ----------------------------------------------------------------------------
// Size class block pool package
// Operation and status codes and the fixed field widths of the pool ports.
// ----------------------------------------------------------------------------
package scbp_pkg;

  localparam int REQ_W    = 10;
  localparam int HANDLE_W = 6;
  localparam int BYTES_W  = 7;
  localparam int CMP_W    = 16;

  typedef enum logic {
    OP_ALLOC,
    OP_RELEASE
  } op_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_TOO_BIG,
    ST_EXHAUSTED,
    ST_BAD_RELEASE
  } status_t;

endpackage

// ===== src/scbp_slot_stack.sv =====
// ----------------------------------------------------------------------------
// Free slot stack storage
// Single write port, single read port memory with a registered read that
// holds its data while the read enable is low.
// ----------------------------------------------------------------------------
module scbp_slot_stack #(
  parameter int DEPTH = 40,
  parameter int AW    = 6,
  parameter int DW    = 3
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/size_class_block_pool.sv =====
// ----------------------------------------------------------------------------
// Size class block pool
// Pool of fixed blocks in power-of-two size classes, each class with a LIFO
// stack of free slots; serves allocate and release requests.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  tdata (low bit up)                      tuser
//   s_*      in   request_bytes[9:0] release_handle[15:10] operation
//   m_*      out  block_handle[5:0] block_bytes[12:6]      status
//
// One transfer is taken every cycle while the output is not stalled; a result
// passes through the input register, which takes the transfer, the middle
// stage, which registers the stack memory read, and the result register.
// Reset needs no clearing pass: a per-class low-water mark tells which stack
// entries still hold their reset contents.
// When m_tready is low with a result waiting, every stage holds and s_tready
// is low.
module size_class_block_pool #(
  parameter int NUM_CLASSES      = 5,
  parameter int SLOTS_PER_CLASS  = 8,
  parameter int BASE_BLOCK_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // request_bytes, release_handle
  input  logic        s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // block_handle, block_bytes, zero fill
  output logic [1:0]  m_tuser    // status
);

  localparam int TOTAL = NUM_CLASSES * SLOTS_PER_CLASS;
  localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int SW    = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1;
  localparam int CW    = $clog2(SLOTS_PER_CLASS + 1);
  localparam int CLW   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int XW0   = $clog2(TOTAL + 1);
  localparam int XW    = (XW0 > scbp_pkg::HANDLE_W) ? XW0 : scbp_pkg::HANDLE_W;

  function automatic logic [scbp_pkg::CMP_W-1:0] class_bytes(input int c);
    class_bytes = scbp_pkg::CMP_W'(BASE_BLOCK_BYTES) << c;
  endfunction

  logic adv;

  // Input stage
  logic                              v1;
  scbp_pkg::op_t                     op1;
  logic [scbp_pkg::REQ_W-1:0]        req1;
  logic [scbp_pkg::HANDLE_W-1:0]     h1;

  // Middle stage
  logic                              v2;
  logic                              pop2;
  scbp_pkg::status_t                 st2;
  logic [scbp_pkg::BYTES_W-1:0]      bytes2;
  logic [scbp_pkg::HANDLE_W-1:0]     outh2;
  logic [CLW-1:0]                    cls2;
  logic                              untouched2;
  logic [SW-1:0]                     init2;

  // Result stage
  scbp_pkg::status_t                 out_status;
  logic [scbp_pkg::HANDLE_W-1:0]     out_handle;
  logic [scbp_pkg::BYTES_W-1:0]      out_bytes;

  // Pool state
  logic [CW-1:0]                     free_count [NUM_CLASSES];
  logic [CW-1:0]                     low_water  [NUM_CLASSES];
  logic [TOTAL-1:0]                  slot_in_use;
  logic [TOTAL-1:0]                  slot_in_use_next;

  // Stack memory
  logic                              rd_en;
  logic [AW-1:0]                     rd_addr;
  logic [SW-1:0]                     rd_data;
  logic                              wr_en;
  logic [AW-1:0]                     wr_addr;
  logic [SW-1:0]                     wr_data;

  // Input stage decode
  logic                              hit;
  logic [CLW-1:0]                    cls;
  logic [CLW-1:0]                    rc;
  logic [XW-1:0]                     h_x;
  logic [XW-1:0]                     rc_base;
  logic                              h_in_range;
  logic [AW-1:0]                     h_idx;
  logic                              in_use;
  logic [CW-1:0]                     cnt_a;
  logic [CW-1:0]                     cnt_r;
  logic                              pop1;
  logic                              rel_ok1;
  scbp_pkg::status_t                 st1;
  logic [scbp_pkg::BYTES_W-1:0]      bytes1;
  logic [scbp_pkg::HANDLE_W-1:0]     outh1;
  logic                              untouched1;
  logic [SW-1:0]                     init1;

  // Middle stage decode
  logic [SW-1:0]                     slot2;
  logic [AW-1:0]                     hnd2;
  logic                              set2;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_comb begin
    hit = 1'b0;
    cls = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (class_bytes(c) >= scbp_pkg::CMP_W'(req1)) begin
        hit = 1'b1;
        cls = CLW'(c);
      end
    end
  end

  always_comb begin
    h_x     = XW'(h1);
    rc      = '0;
    rc_base = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (h_x >= XW'(c * SLOTS_PER_CLASS)) begin
        rc      = CLW'(c);
        rc_base = XW'(c * SLOTS_PER_CLASS);
      end
    end
  end

  assign h_in_range = h_x < XW'(TOTAL);
  assign h_idx      = h_x[AW-1:0];
  assign cnt_a      = free_count[cls];
  assign cnt_r      = free_count[rc];
  assign in_use     = slot_in_use[h_idx] || (set2 && (XW'(hnd2) == h_x));
  assign untouched1 = cnt_a == low_water[cls];
  assign init1      = SW'(CW'(SLOTS_PER_CLASS) - cnt_a);

  always_comb begin
    pop1    = 1'b0;
    rel_ok1 = 1'b0;
    st1     = scbp_pkg::ST_OK;
    bytes1  = '0;
    outh1   = '0;
    if (op1 == scbp_pkg::OP_ALLOC) begin
      priority if (!hit) begin
        st1 = scbp_pkg::ST_TOO_BIG;
      end else if (cnt_a == '0) begin
        st1    = scbp_pkg::ST_EXHAUSTED;
        bytes1 = scbp_pkg::BYTES_W'(class_bytes(int'(cls)));
      end else begin
        pop1   = 1'b1;
        bytes1 = scbp_pkg::BYTES_W'(class_bytes(int'(cls)));
      end
    end else begin
      outh1 = h1;
      priority if (!h_in_range) begin
        st1 = scbp_pkg::ST_BAD_RELEASE;
      end else if (!in_use || cnt_r >= CW'(SLOTS_PER_CLASS)) begin
        st1    = scbp_pkg::ST_BAD_RELEASE;
        bytes1 = scbp_pkg::BYTES_W'(class_bytes(int'(rc)));
      end else begin
        rel_ok1 = 1'b1;
        bytes1  = scbp_pkg::BYTES_W'(class_bytes(int'(rc)));
      end
    end
  end

  assign rd_en   = adv && v1 && pop1;
  assign rd_addr = AW'(cls) * AW'(SLOTS_PER_CLASS) + AW'(cnt_a - CW'(1));
  assign wr_en   = adv && v1 && rel_ok1;
  assign wr_addr = AW'(rc) * AW'(SLOTS_PER_CLASS) + AW'(cnt_r);
  assign wr_data = SW'(h_x - rc_base);

  scbp_slot_stack #(
    .DEPTH (TOTAL),
    .AW    (AW),
    .DW    (SW)
  ) u_stack (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign slot2 = untouched2 ? init2 : rd_data;
  assign hnd2  = AW'(cls2) * AW'(SLOTS_PER_CLASS) + AW'(slot2);
  assign set2  = v2 && pop2;

  // A release of the handle that the older pop has just taken comes later,
  // so its clear overrides the set.
  always_comb begin
    slot_in_use_next = slot_in_use;
    if (set2) begin
      slot_in_use_next[hnd2] = 1'b1;
    end
    if (v1 && rel_ok1) begin
      slot_in_use_next[h_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1          <= 1'b0;
      v2          <= 1'b0;
      m_tvalid    <= 1'b0;
      slot_in_use <= '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        free_count[c] <= CW'(SLOTS_PER_CLASS);
        low_water[c]  <= CW'(SLOTS_PER_CLASS);
      end
    end else if (adv) begin
      v1          <= s_tvalid;
      v2          <= v1;
      m_tvalid    <= v2;
      slot_in_use <= slot_in_use_next;
      if (v1 && pop1) begin
        free_count[cls] <= cnt_a - CW'(1);
        if (untouched1) begin
          low_water[cls] <= cnt_a - CW'(1);
        end
      end
      if (v1 && rel_ok1) begin
        free_count[rc] <= cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1        <= scbp_pkg::op_t'(s_tuser);
      req1       <= s_tdata[scbp_pkg::REQ_W-1:0];
      h1         <= s_tdata[scbp_pkg::REQ_W +: scbp_pkg::HANDLE_W];
      pop2       <= pop1;
      st2        <= st1;
      bytes2     <= bytes1;
      outh2      <= outh1;
      cls2       <= cls;
      untouched2 <= untouched1;
      init2      <= init1;
      out_status <= st2;
      out_bytes  <= bytes2;
      out_handle <= pop2 ? scbp_pkg::HANDLE_W'(hnd2) : outh2;
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {3'b000, out_bytes, out_handle};

endmodule

// ===== test/size_class_block_pool_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Size class block pool checker
// Watches both stream channels of the pool. Every accepted request is run
// through a local model of the size class stacks, and the predicted result
// is queued; every accepted result is compared field by field with the
// oldest queued prediction.
// ----------------------------------------------------------------------------
module size_class_block_pool_checker #(
  parameter int NUM_CLASSES      = 5,
  parameter int SLOTS_PER_CLASS  = 8,
  parameter int BASE_BLOCK_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // request_bytes, release_handle
  input  logic        s_tuser,   // operation
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // block_handle, block_bytes, zero fill
  input  logic [1:0]  m_tuser,   // status
  output int          fail_count,
  output int          pending
);

  localparam int TOTAL_SLOTS = NUM_CLASSES * SLOTS_PER_CLASS;
  localparam int HW          = scbp_pkg::HANDLE_W;
  localparam int BW          = scbp_pkg::BYTES_W;
  localparam int RW          = scbp_pkg::REQ_W;

  typedef struct packed {
    scbp_pkg::status_t  status;
    logic [HW-1:0]      handle;
    logic [BW-1:0]      bytes;
  } pool_result_t;

  logic [2:0] free_stack [NUM_CLASSES][SLOTS_PER_CLASS];
  logic [3:0] free_slots [NUM_CLASSES];
  logic       in_use     [TOTAL_SLOTS];

  pool_result_t expected_q[$];

  function automatic logic [BW-1:0] class_size(int c);
    int sz;
    sz = BASE_BLOCK_BYTES << c;
    return sz[BW-1:0];
  endfunction

  // Applies one request to the local stacks and returns the result it gives.
  function automatic pool_result_t serve_request(scbp_pkg::op_t op, logic [RW-1:0] req,
                                                 logic [HW-1:0] h);
    pool_result_t res;
    int c;
    int chosen;
    int top;
    int slot;
    int hnd;
    chosen = -1;
    res.status = scbp_pkg::ST_OK;
    res.handle = '0;
    res.bytes  = '0;
    if (op == scbp_pkg::OP_ALLOC) begin
      for (c = NUM_CLASSES - 1; c >= 0; c--) begin
        if ((BASE_BLOCK_BYTES << c) >= int'(req)) chosen = c;
      end
      if (chosen < 0) begin
        res.status = scbp_pkg::ST_TOO_BIG;
      end else if (free_slots[chosen] == 0 || free_slots[chosen] > SLOTS_PER_CLASS) begin
        res.status = scbp_pkg::ST_EXHAUSTED;
        res.bytes  = class_size(chosen);
      end else begin
        top  = int'(free_slots[chosen]) - 1;
        slot = int'(free_stack[chosen][top]) % SLOTS_PER_CLASS;
        hnd  = chosen * SLOTS_PER_CLASS + slot;
        free_slots[chosen] = top[3:0];
        in_use[hnd] = 1'b1;
        res.handle = hnd[HW-1:0];
        res.bytes  = class_size(chosen);
      end
    end else begin
      res.handle = h;
      if (int'(h) >= TOTAL_SLOTS) begin
        res.status = scbp_pkg::ST_BAD_RELEASE;
      end else begin
        hnd  = int'(h);
        c    = hnd / SLOTS_PER_CLASS;
        slot = hnd % SLOTS_PER_CLASS;
        res.bytes = class_size(c);
        if (!in_use[hnd] || free_slots[c] >= SLOTS_PER_CLASS) begin
          res.status = scbp_pkg::ST_BAD_RELEASE;
        end else begin
          free_stack[c][free_slots[c]] = slot[2:0];
          free_slots[c] = free_slots[c] + 4'd1;
          in_use[hnd] = 1'b0;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    pool_result_t exp_res;
    pool_result_t got;
    int errs;
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        for (int k = 0; k < SLOTS_PER_CLASS; k++) begin
          free_stack[c][k] = 3'(SLOTS_PER_CLASS - 1 - k);
        end
        free_slots[c] = 4'(SLOTS_PER_CLASS);
      end
      for (int h = 0; h < TOTAL_SLOTS; h++) in_use[h] = 1'b0;
      expected_q.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_q.push_back(serve_request(scbp_pkg::op_t'(s_tuser), s_tdata[RW-1:0],
                                           s_tdata[RW+HW-1:RW]));
      end
      if (m_tvalid && m_tready) begin
        got.status = scbp_pkg::status_t'(m_tuser);
        got.handle = m_tdata[HW-1:0];
        got.bytes  = m_tdata[HW+BW-1:HW];
        if (expected_q.size() == 0) begin
          $error("unexpected result: status %0d handle %0d bytes %0d",
                 got.status, got.handle, got.bytes);
          fail_count <= fail_count + 1;
        end else begin
          exp_res = expected_q.pop_front();
          errs = 0;
          if (got.status !== exp_res.status) begin
            $error("status: expected %0d, actual %0d", exp_res.status, got.status);
            errs++;
          end
          if (got.handle !== exp_res.handle) begin
            $error("block_handle: expected %0d, actual %0d", exp_res.handle, got.handle);
            errs++;
          end
          if (got.bytes !== exp_res.bytes) begin
            $error("block_bytes: expected %0d, actual %0d", exp_res.bytes, got.bytes);
            errs++;
          end
          if (m_tdata[15:HW+BW] !== '0) begin
            $error("tdata fill: expected 0, actual %0d", m_tdata[15:HW+BW]);
            errs++;
          end
          fail_count <= fail_count + errs;
        end
      end
      pending <= expected_q.size();
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Size class block pool testbench
// Drives directed requests over the class boundaries, out-of-range and
// double releases and class exhaustion, then random phases of allocate-heavy,
// mixed and release-heavy traffic with random gaps and result stalls. The checker
// beside the pool predicts and compares every transfer.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int NUM_CLASSES_TB = 5;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;

  int fail_count;
  int pending;
  int cycles = 0;
  int ready_hold = 0;
  int ready_roll;
  bit quiet = 1'b0;

  size_class_block_pool dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  size_class_block_pool_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[size_class_block_pool] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (quiet || ready_roll < 60) begin
        m_tready   <= 1'b1;
        ready_hold <= $urandom_range(0, 7);
      end else if (ready_roll < 95) begin
        m_tready   <= 1'b0;
        ready_hold <= $urandom_range(0, 3);
      end else begin
        m_tready   <= 1'b0;
        ready_hold <= $urandom_range(10, 30);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  task automatic send_request(scbp_pkg::op_t op, int req, int h);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {h[scbp_pkg::HANDLE_W-1:0], req[scbp_pkg::REQ_W-1:0]};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic alloc(int req);
    send_request(scbp_pkg::OP_ALLOC, req, $urandom_range(0, 63));
  endtask

  task automatic release_block(int h);
    send_request(scbp_pkg::OP_RELEASE, $urandom_range(0, 1023), h);
  endtask

  initial begin
    int alloc_pct;
    int r;
    int k;
    int req;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    alloc(0);
    alloc(1023);
    alloc(4);
    alloc(5);
    alloc(64);
    alloc(65);
    release_block(63);
    release_block(40);
    release_block(39);
    release_block(32);
    release_block(32);
    release_block(0);
    alloc(0);
    for (int i = 0; i < 8; i++) alloc(i[0] ? 33 : 64);
    alloc(64);
    release_block(39);
    alloc(40);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 3)
        0: alloc_pct = 80;
        1: alloc_pct = 50;
        default: alloc_pct = 20;
      endcase
      quiet = (phase == 2 || phase == 5);
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(0, 99) < alloc_pct) begin
          r = $urandom_range(0, 99);
          if (r < 10) begin
            req = $urandom_range(0, 1023);
          end else if (r < 15) begin
            req = 0;
          end else begin
            k = $urandom_range(0, NUM_CLASSES_TB - 1);
            req = (k == 0) ? $urandom_range(0, 4) : $urandom_range((2 << k) + 1, 4 << k);
          end
          alloc(req);
        end else if ($urandom_range(0, 99) < 85) begin
          release_block($urandom_range(0, 39));
        end else begin
          release_block($urandom_range(40, 63));
        end
      end
    end
    quiet = 1'b0;
    s_tvalid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("[size_class_block_pool] OK");
    end else begin
      $display("[size_class_block_pool] ERROR");
    end
    $finish;
  end

endmodule

// ===== size_class_block_pool.f =====
src/scbp_pkg.sv
src/scbp_slot_stack.sv
src/size_class_block_pool.sv
test/size_class_block_pool_checker.sv
test/tb.sv
